// ===== design/mtep_pkg.sv =====
// shared types, phase codes and record kinds for the track event parser
package mtep_pkg;

  // parse phase codes
  localparam logic [3:0] PH_DELTA      = 4'd0;
  localparam logic [3:0] PH_STATUS     = 4'd1;
  localparam logic [3:0] PH_DATA1      = 4'd2;
  localparam logic [3:0] PH_DATA2      = 4'd3;
  localparam logic [3:0] PH_META_TYPE  = 4'd4;
  localparam logic [3:0] PH_META_LEN   = 4'd5;
  localparam logic [3:0] PH_META_BODY  = 4'd6;
  localparam logic [3:0] PH_SYSEX_LEN  = 4'd7;
  localparam logic [3:0] PH_SYSEX_BODY = 4'd8;

  // record kinds
  localparam logic [2:0] KIND_CHANNEL   = 3'd0;
  localparam logic [2:0] KIND_META_HDR  = 3'd1;
  localparam logic [2:0] KIND_META_BYTE = 3'd2;
  localparam logic [2:0] KIND_SYSEX_HDR = 3'd3;
  localparam logic [2:0] KIND_BAD       = 3'd4;

  // status bytes with special meaning
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [31:0] pulse_time;
    logic [31:0] delta_ticks;
    logic [7:0]  status_byte;
    logic [3:0]  message_code;
    logic [3:0]  channel_number;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [7:0]  meta_type;
    logic [31:0] body_length;
    logic        status_restored;
    logic        last_payload;
  } out_item_t;

endpackage

// ===== design/mtep_parser.sv =====
// parser state registers and the combinational per-byte step logic
module mtep_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  mtep_pkg::in_item_t item,
  output logic               res_valid,
  output mtep_pkg::out_item_t res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [7:0]  cur_st_r, cur_st_nxt;
  logic [7:0]  saved_st_r, saved_st_nxt;
  logic        rs_seen_r, rs_seen_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  held_mt_r, held_mt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;

  // view of the state after an optional track restart
  logic [3:0]  phase_e;
  logic [31:0] delta_e, tick_e, len_e, left_e;
  logic [7:0]  cur_st_e, saved_st_e, held_e, held_mt_e;
  logic        rs_seen_e;

  logic [7:0]  b;
  logic [31:0] delta_sh, len_sh, left_dec;
  logic [7:0]  run_st;

  function automatic logic valid_channel(input logic [7:0] st);
    return st[7] && (st[7:4] != 4'hF);
  endfunction

  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == 4'hC) || (st[7:4] == 4'hD);
  endfunction

  function automatic mtep_pkg::out_item_t make_rec(
    input logic [2:0]  kind,
    input logic [31:0] tick,
    input logic [31:0] delta,
    input logic [7:0]  st,
    input logic [7:0]  d1,
    input logic [7:0]  d2,
    input logic [7:0]  mt,
    input logic [31:0] blen,
    input logic        restored,
    input logic        last
  );
    mtep_pkg::out_item_t r;
    logic chan, meta, body;
    chan = (kind == mtep_pkg::KIND_CHANNEL) || (kind == mtep_pkg::KIND_BAD);
    meta = (kind == mtep_pkg::KIND_META_HDR) || (kind == mtep_pkg::KIND_META_BYTE);
    body = meta || (kind == mtep_pkg::KIND_SYSEX_HDR);
    r.record_kind     = kind;
    r.pulse_time      = tick;
    r.delta_ticks     = delta;
    r.status_byte     = st;
    r.message_code    = chan ? st[7:4] : 4'h0;
    r.channel_number  = chan ? st[3:0] : 4'h0;
    r.first_data      = d1;
    r.second_data     = d2;
    r.meta_type       = meta ? mt : 8'h00;
    r.body_length     = body ? blen : 32'h0;
    r.status_restored = restored;
    r.last_payload    = last;
    return r;
  endfunction

  // restart on track start
  always_comb begin
    b = item.data_byte;
    if (item.track_start) begin
      phase_e    = mtep_pkg::PH_DELTA;
      delta_e    = '0;
      tick_e     = '0;
      cur_st_e   = '0;
      saved_st_e = '0;
      rs_seen_e  = 1'b0;
      held_e     = '0;
      held_mt_e  = '0;
      len_e      = '0;
      left_e     = '0;
    end else begin
      phase_e    = phase_r;
      delta_e    = delta_r;
      tick_e     = tick_r;
      cur_st_e   = cur_st_r;
      saved_st_e = saved_st_r;
      rs_seen_e  = rs_seen_r;
      held_e     = held_r;
      held_mt_e  = held_mt_r;
      len_e      = len_r;
      left_e     = left_r;
    end
    delta_sh = {delta_e[24:0], b[6:0]};
    len_sh   = {len_e[24:0], b[6:0]};
    left_dec = (left_e != 32'h0) ? (left_e - 32'h1) : 32'h0;
    run_st   = rs_seen_e ? saved_st_e : cur_st_e;
  end

  // per-byte step
  always_comb begin
    phase_nxt    = phase_e;
    delta_nxt    = delta_e;
    tick_nxt     = tick_e;
    cur_st_nxt   = cur_st_e;
    saved_st_nxt = saved_st_e;
    rs_seen_nxt  = rs_seen_e;
    held_nxt     = held_e;
    held_mt_nxt  = held_mt_e;
    len_nxt      = len_e;
    left_nxt     = left_e;
    res_valid    = 1'b0;
    res = make_rec(mtep_pkg::KIND_CHANNEL, tick_e, delta_e, cur_st_e, 8'h00, 8'h00,
                   held_mt_e, len_e, 1'b0, 1'b0);
    case (phase_e)
      mtep_pkg::PH_STATUS: begin
        if (b == mtep_pkg::ST_META || b == mtep_pkg::ST_SYSEX ||
            b == mtep_pkg::ST_SYSEX_ESC) begin
          // meta or sysex: keep running status once
          if (!rs_seen_e) begin
            rs_seen_nxt  = 1'b1;
            saved_st_nxt = cur_st_e;
          end
          cur_st_nxt = b;
          len_nxt    = '0;
          phase_nxt  = (b == mtep_pkg::ST_META) ? mtep_pkg::PH_META_TYPE
                                                : mtep_pkg::PH_SYSEX_LEN;
        end else if (b[7]) begin
          // new status byte
          cur_st_nxt  = b;
          rs_seen_nxt = 1'b0;
          if (valid_channel(b)) begin
            phase_nxt = mtep_pkg::PH_DATA1;
          end else begin
            res_valid = 1'b1;
            res = make_rec(mtep_pkg::KIND_BAD, tick_e, delta_e, b, 8'h00, 8'h00,
                           held_mt_e, len_e, 1'b0, 1'b0);
            phase_nxt = mtep_pkg::PH_DELTA;
            delta_nxt = '0;
          end
        end else begin
          // running status, restoring a saved status if there is one
          cur_st_nxt = run_st;
          if (valid_channel(run_st)) begin
            if (one_data(run_st)) begin
              res_valid = 1'b1;
              res = make_rec(mtep_pkg::KIND_CHANNEL, tick_e, delta_e, run_st, b, 8'h00,
                             held_mt_e, len_e, rs_seen_e, 1'b0);
              rs_seen_nxt = 1'b0;
              phase_nxt   = mtep_pkg::PH_DELTA;
              delta_nxt   = '0;
            end else begin
              held_nxt  = b;
              phase_nxt = mtep_pkg::PH_DATA2;
            end
          end else begin
            // no usable status: report, then the byte is a one-byte delta
            res_valid = 1'b1;
            res = make_rec(mtep_pkg::KIND_BAD, tick_e, delta_e, run_st, 8'h00, 8'h00,
                           held_mt_e, len_e, rs_seen_e, 1'b0);
            rs_seen_nxt = 1'b0;
            delta_nxt   = {25'h0, b[6:0]};
            tick_nxt    = tick_e + {25'h0, b[6:0]};
            phase_nxt   = mtep_pkg::PH_STATUS;
          end
        end
      end
      mtep_pkg::PH_DATA1: begin
        if (one_data(cur_st_e)) begin
          res_valid = 1'b1;
          res = make_rec(mtep_pkg::KIND_CHANNEL, tick_e, delta_e, cur_st_e, b, 8'h00,
                         held_mt_e, len_e, rs_seen_e, 1'b0);
          rs_seen_nxt = 1'b0;
          phase_nxt   = mtep_pkg::PH_DELTA;
          delta_nxt   = '0;
        end else begin
          held_nxt  = b;
          phase_nxt = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        res_valid = 1'b1;
        res = make_rec(mtep_pkg::KIND_CHANNEL, tick_e, delta_e, cur_st_e, held_e, b,
                       held_mt_e, len_e, rs_seen_e, 1'b0);
        rs_seen_nxt = 1'b0;
        phase_nxt   = mtep_pkg::PH_DELTA;
        delta_nxt   = '0;
      end
      mtep_pkg::PH_META_TYPE: begin
        held_mt_nxt = b;
        len_nxt     = '0;
        phase_nxt   = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN: begin
        len_nxt = len_sh;
        if (!b[7]) begin
          left_nxt  = len_sh;
          res_valid = 1'b1;
          res = make_rec(mtep_pkg::KIND_META_HDR, tick_e, delta_e, cur_st_e, 8'h00, 8'h00,
                         held_mt_e, len_sh, 1'b0, len_sh == 32'h0);
          if (len_sh == 32'h0) begin
            phase_nxt = mtep_pkg::PH_DELTA;
            delta_nxt = '0;
          end else begin
            phase_nxt = mtep_pkg::PH_META_BODY;
          end
        end
      end
      mtep_pkg::PH_META_BODY: begin
        left_nxt  = left_dec;
        res_valid = 1'b1;
        res = make_rec(mtep_pkg::KIND_META_BYTE, tick_e, delta_e, cur_st_e, b, 8'h00,
                       held_mt_e, len_e, 1'b0, left_dec == 32'h0);
        if (left_dec == 32'h0) begin
          phase_nxt = mtep_pkg::PH_DELTA;
          delta_nxt = '0;
        end
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        len_nxt = len_sh;
        if (!b[7]) begin
          left_nxt  = len_sh;
          res_valid = 1'b1;
          res = make_rec(mtep_pkg::KIND_SYSEX_HDR, tick_e, delta_e, cur_st_e, 8'h00, 8'h00,
                         held_mt_e, len_sh, 1'b0, 1'b0);
          if (len_sh == 32'h0) begin
            phase_nxt = mtep_pkg::PH_DELTA;
            delta_nxt = '0;
          end else begin
            phase_nxt = mtep_pkg::PH_SYSEX_BODY;
          end
        end
      end
      mtep_pkg::PH_SYSEX_BODY: begin
        // payload is skipped
        left_nxt = left_dec;
        if (left_dec == 32'h0) begin
          phase_nxt = mtep_pkg::PH_DELTA;
          delta_nxt = '0;
        end
      end
      default: begin
        // delta bytes, and any unused phase code
        delta_nxt = delta_sh;
        if (b[7]) begin
          phase_nxt = mtep_pkg::PH_DELTA;
        end else begin
          tick_nxt  = tick_e + delta_sh;
          phase_nxt = mtep_pkg::PH_STATUS;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mtep_pkg::PH_DELTA;
      delta_r    <= '0;
      tick_r     <= '0;
      cur_st_r   <= '0;
      saved_st_r <= '0;
      rs_seen_r  <= 1'b0;
      held_r     <= '0;
      held_mt_r  <= '0;
      len_r      <= '0;
      left_r     <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      delta_r    <= delta_nxt;
      tick_r     <= tick_nxt;
      cur_st_r   <= cur_st_nxt;
      saved_st_r <= saved_st_nxt;
      rs_seen_r  <= rs_seen_nxt;
      held_r     <= held_nxt;
      held_mt_r  <= held_mt_nxt;
      len_r      <= len_nxt;
      left_r     <= left_nxt;
    end
  end

  // a restored status is only ever reported on channel or bad-status records
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status_restored |->
      (res.record_kind == mtep_pkg::KIND_CHANNEL || res.record_kind == mtep_pkg::KIND_BAD))
    else $error("restored flag on a meta or sysex record");

  // a data phase always runs under a channel status
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mtep_pkg::PH_DATA1 || phase_r == mtep_pkg::PH_DATA2) |->
      valid_channel(cur_st_r))
    else $error("data phase without a channel status");

  // body phases never sit with nothing left
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mtep_pkg::PH_META_BODY || phase_r == mtep_pkg::PH_SYSEX_BODY) |->
      (left_r != 32'h0))
    else $error("body phase with zero bytes left");

endmodule

// ===== design/midi_track_event_parser_core.sv =====
// top level: input register, parser step and result register
//
//  channel   ports                          moves
//  input     in_valid  in_stall  in_item    one track byte per item
//  result    out_valid out_stall out_item   one parsed record per item
//
// each byte passes from the input register through the parser step
// into the result register; one byte a cycle is sustained while out_stall is low
// the 32-bit delta shift-add feeding the pulse time add sets the critical path
// rst_n (synchronous) empties both registers and returns the parser to expecting delta
// with a record held under out_stall, a byte that waits in the input register holds
module midi_track_event_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mtep_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mtep_pkg::out_item_t  out_item
);

  logic                in_valid_r, in_valid_nxt;
  mtep_pkg::in_item_t  in_item_r;
  logic                out_valid_r, out_valid_nxt;
  mtep_pkg::out_item_t out_item_r;
  logic                advance, in_take;
  logic                res_valid;
  mtep_pkg::out_item_t res;

  // a byte is processed when the result slot is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  mtep_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // input register control
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // result register control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a waiting byte stays put until it is processed
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("waiting input byte lost or changed");

  // a held record is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !advance)
    else $error("parser stepped over a stalled record");

  // record kind stays within the defined set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.record_kind <= mtep_pkg::KIND_BAD)
    else $error("undefined record kind");

endmodule

// ===== dv/midi_track_event_parser_core_test.sv =====
// testbench for the track event parser: byte streams checked against a local parse model
module midi_track_event_parser_core_test;

  // message type nibbles of channel status bytes
  localparam logic [3:0] MSG_NOTE_ON       = 4'h9;
  localparam logic [3:0] MSG_PROGRAM       = 4'hC;
  localparam logic [3:0] MSG_CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] MSG_FIRST         = 4'h8;
  localparam logic [3:0] MSG_LAST          = 4'hE;

  // status and meta codes used by the stimulus
  localparam logic [7:0] ST_CHAN_FIRST    = 8'h80;
  localparam logic [7:0] ST_SYS_FIRST     = 8'hF1;
  localparam logic [7:0] ST_SYS_LAST      = 8'hFE;
  localparam logic [7:0] META_TXT         = 8'h01;
  localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
  localparam logic [7:0] VLQ_MORE         = 8'h80;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                out_stall = 1'b0;
  mtep_pkg::in_item_t  in_item   = '0;
  logic                in_stall;
  logic                out_valid;
  mtep_pkg::out_item_t out_item;

  midi_track_event_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parse model state
  logic [3:0]  phase;
  logic [31:0] delta_acc;
  logic [31:0] tick;
  logic [7:0]  cur_status;
  logic [7:0]  saved_status;
  logic        restore_pending;
  logic [7:0]  held_data;
  logic [7:0]  held_meta_type;
  logic [31:0] length_acc;
  logic [31:0] body_left;

  mtep_pkg::out_item_t pending_records[$];
  logic [7:0]  chunk[$];
  logic [7:0]  last_status;
  int          errors     = 0;
  int          cycles     = 0;
  int          sent_bytes = 0;
  int          stall_left = 0;
  bit          idle_on    = 1'b1;

  // append one byte to the chunk under construction
  task automatic add_chunk_byte(input logic [7:0] v);
    chunk = {chunk, v};
  endtask

  function automatic bit is_channel_status(input logic [7:0] st);
    return st >= ST_CHAN_FIRST && st < mtep_pkg::ST_SYSEX;
  endfunction

  function automatic bit takes_one_data(input logic [7:0] st);
    return st[7:4] == MSG_PROGRAM || st[7:4] == MSG_CHAN_PRESSURE;
  endfunction

  // build one expected record from the current model state
  task automatic queue_record(input logic [2:0] kind, input logic [7:0] st,
                              input logic [7:0] d1, input logic [7:0] d2,
                              input logic last, input logic restored);
    mtep_pkg::out_item_t r;
    logic      chan;
    logic      meta;
    logic      body;
    chan = kind == mtep_pkg::KIND_CHANNEL || kind == mtep_pkg::KIND_BAD;
    meta = kind == mtep_pkg::KIND_META_HDR || kind == mtep_pkg::KIND_META_BYTE;
    body = meta || kind == mtep_pkg::KIND_SYSEX_HDR;
    r.record_kind     = kind;
    r.pulse_time      = tick;
    r.delta_ticks     = delta_acc;
    r.status_byte     = st;
    r.message_code    = chan ? st[7:4] : 4'h0;
    r.channel_number  = chan ? st[3:0] : 4'h0;
    r.first_data      = d1;
    r.second_data     = d2;
    r.meta_type       = meta ? held_meta_type : 8'h00;
    r.body_length     = body ? length_acc : 32'h0;
    r.status_restored = restored;
    r.last_payload    = last;
    pending_records = {pending_records, r};
  endtask

  task automatic clear_parse_state();
    phase           = mtep_pkg::PH_DELTA;
    delta_acc       = '0;
    tick            = '0;
    cur_status      = '0;
    saved_status    = '0;
    restore_pending = 1'b0;
    held_data       = '0;
    held_meta_type  = '0;
    length_acc      = '0;
    body_left       = '0;
  endtask

  task automatic end_event();
    phase     = mtep_pkg::PH_DELTA;
    delta_acc = '0;
  endtask

  // one byte of the variable-length delta, time advances on the last one
  task automatic take_delta_byte(input logic [7:0] b);
    delta_acc = (delta_acc << 7) + {25'd0, b[6:0]};
    if (b[7]) begin
      phase = mtep_pkg::PH_DELTA;
    end else begin
      tick  = tick + delta_acc;
      phase = mtep_pkg::PH_STATUS;
    end
  endtask

  // advance the parse model by one track byte
  task automatic parse_track_byte(input logic [7:0] b, input logic ts);
    logic restored;
    if (ts) clear_parse_state();
    case (phase)
      mtep_pkg::PH_STATUS: begin
        if (b == mtep_pkg::ST_META || b == mtep_pkg::ST_SYSEX ||
            b == mtep_pkg::ST_SYSEX_ESC) begin
          if (!restore_pending) begin
            restore_pending = 1'b1;
            saved_status    = cur_status;
          end
          cur_status = b;
          length_acc = '0;
          phase      = (b == mtep_pkg::ST_META) ? mtep_pkg::PH_META_TYPE
                                                : mtep_pkg::PH_SYSEX_LEN;
        end else if (b[7]) begin
          cur_status      = b;
          restore_pending = 1'b0;
          if (is_channel_status(b)) begin
            phase = mtep_pkg::PH_DATA1;
          end else begin
            queue_record(mtep_pkg::KIND_BAD, b, 8'h00, 8'h00, 1'b0, 1'b0);
            end_event();
          end
        end else begin
          // running status, possibly brought back after meta or sysex
          if (restore_pending) cur_status = saved_status;
          restored = restore_pending;
          if (is_channel_status(cur_status)) begin
            if (takes_one_data(cur_status)) begin
              queue_record(mtep_pkg::KIND_CHANNEL, cur_status, b, 8'h00, 1'b0, restored);
              restore_pending = 1'b0;
              end_event();
            end else begin
              held_data = b;
              phase     = mtep_pkg::PH_DATA2;
            end
          end else begin
            queue_record(mtep_pkg::KIND_BAD, cur_status, 8'h00, 8'h00, 1'b0, restored);
            restore_pending = 1'b0;
            end_event();
            take_delta_byte(b);
          end
        end
      end
      mtep_pkg::PH_DATA1: begin
        if (takes_one_data(cur_status)) begin
          queue_record(mtep_pkg::KIND_CHANNEL, cur_status, b, 8'h00, 1'b0,
                       restore_pending);
          restore_pending = 1'b0;
          end_event();
        end else begin
          held_data = b;
          phase     = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        queue_record(mtep_pkg::KIND_CHANNEL, cur_status, held_data, b, 1'b0,
                     restore_pending);
        restore_pending = 1'b0;
        end_event();
      end
      mtep_pkg::PH_META_TYPE: begin
        held_meta_type = b;
        length_acc     = '0;
        phase          = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN: begin
        length_acc = (length_acc << 7) + {25'd0, b[6:0]};
        if (!b[7]) begin
          body_left = length_acc;
          queue_record(mtep_pkg::KIND_META_HDR, cur_status, 8'h00, 8'h00,
                       body_left == 0, 1'b0);
          if (body_left == 0) end_event();
          else phase = mtep_pkg::PH_META_BODY;
        end
      end
      mtep_pkg::PH_META_BODY: begin
        if (body_left != 0) body_left = body_left - 1;
        queue_record(mtep_pkg::KIND_META_BYTE, cur_status, b, 8'h00, body_left == 0, 1'b0);
        if (body_left == 0) end_event();
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        length_acc = (length_acc << 7) + {25'd0, b[6:0]};
        if (!b[7]) begin
          queue_record(mtep_pkg::KIND_SYSEX_HDR, cur_status, 8'h00, 8'h00, 1'b0, 1'b0);
          body_left = length_acc;
          if (body_left == 0) end_event();
          else phase = mtep_pkg::PH_SYSEX_BODY;
        end
      end
      mtep_pkg::PH_SYSEX_BODY: begin
        if (body_left != 0) body_left = body_left - 1;
        if (body_left == 0) end_event();
      end
      default: begin
        take_delta_byte(b);
      end
    endcase
  endtask

  // send one byte, with an occasional gap before it; called at a falling edge
  task automatic send_track_byte(input logic [7:0] b, input logic ts);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_item  <= '{data_byte: b, track_start: ts};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_track_byte(b, ts);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_chunk(input logic new_track);
    foreach (chunk[i]) send_track_byte(chunk[i], new_track && i == 0);
  endtask

  // length field, now and then with a redundant leading zero group
  task automatic push_length(input int unsigned value);
    logic [7:0]  groups[$];
    int unsigned v;
    v = value;
    groups.push_front(8'(v & 32'h7F));
    v = v >> 7;
    while (v != 0) begin
      groups.push_front(8'(v & 32'h7F) | VLQ_MORE);
      v = v >> 7;
    end
    if ($urandom_range(0, 7) == 0) groups.push_front(VLQ_MORE);
    foreach (groups[i]) add_chunk_byte(groups[i]);
  endtask

  // one event with random delta and content, mostly well formed
  task automatic build_random_event();
    int         pick;
    int         n;
    int         len;
    logic [7:0] st;
    chunk.delete();
    pick = $urandom_range(0, 99);
    n = pick < 70 ? 1 : pick < 90 ? 2 : pick < 97 ? $urandom_range(3, 4) : 5;
    for (int i = 0; i < n - 1; i++) add_chunk_byte(8'($urandom) | VLQ_MORE);
    add_chunk_byte(8'($urandom) & ~VLQ_MORE);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      st = {4'($urandom_range(MSG_FIRST, MSG_LAST)), 4'($urandom)};
      last_status = st;
      add_chunk_byte(st);
      add_chunk_byte(8'($urandom));
      if (!takes_one_data(st)) add_chunk_byte(8'($urandom));
    end else if (pick < 60) begin
      add_chunk_byte(8'($urandom_range(0, 127)));
      if (is_channel_status(last_status) && !takes_one_data(last_status))
        add_chunk_byte(8'($urandom));
    end else if (pick < 75) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 150) : $urandom_range(0, 6);
      add_chunk_byte(mtep_pkg::ST_META);
      add_chunk_byte(8'($urandom));
      push_length(len);
      repeat (len) add_chunk_byte(8'($urandom));
    end else if (pick < 90) begin
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 8);
      add_chunk_byte($urandom_range(0, 1) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_SYSEX_ESC);
      push_length(len);
      repeat (len) add_chunk_byte(8'($urandom));
    end else if (pick < 95) begin
      do st = 8'($urandom_range(ST_SYS_FIRST, ST_SYS_LAST));
      while (st == mtep_pkg::ST_SYSEX_ESC);
      last_status = st;
      add_chunk_byte(st);
    end else begin
      // raw noise
      repeat ($urandom_range(1, 3)) add_chunk_byte(8'($urandom));
    end
  endtask

  // random tracks; some events are cut short by a new track
  task automatic run_tracks(input int stop_at);
    logic new_track;
    logic broken;
    int   keep;
    new_track = 1'b1;
    while (sent_bytes < stop_at) begin
      if (new_track) last_status = '0;
      build_random_event();
      broken = chunk.size() > 1 && $urandom_range(0, 24) == 0;
      if (broken) begin
        keep = $urandom_range(1, chunk.size() - 1);
        while (chunk.size() > keep) void'(chunk.pop_back());
      end
      send_chunk(new_track);
      new_track = broken || $urandom_range(0, 39) == 0;
    end
  endtask

  // receiver stalls in bursts, only while gaps are enabled
  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_record(input mtep_pkg::out_item_t want,
                              input mtep_pkg::out_item_t got);
    check_field("record_kind", want.record_kind, got.record_kind);
    check_field("pulse_time", want.pulse_time, got.pulse_time);
    check_field("delta_ticks", want.delta_ticks, got.delta_ticks);
    check_field("status_byte", want.status_byte, got.status_byte);
    check_field("message_code", want.message_code, got.message_code);
    check_field("channel_number", want.channel_number, got.channel_number);
    check_field("first_data", want.first_data, got.first_data);
    check_field("second_data", want.second_data, got.second_data);
    check_field("meta_type", want.meta_type, got.meta_type);
    check_field("body_length", want.body_length, got.body_length);
    check_field("status_restored", want.status_restored, got.status_restored);
    check_field("last_payload", want.last_payload, got.last_payload);
  endtask

  // compare each accepted record with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: record with none expected, actual %p", $time, out_item);
      end else begin
        check_record(pending_records.pop_front(), out_item);
      end
    end
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // channel messages: extremes of data, high-bit data, one and two data bytes
  task automatic test_channel_messages();
    chunk = '{8'h00, {MSG_NOTE_ON, 4'h0}, 8'h00, 8'h7F};
    send_chunk(1'b1);
    chunk = '{8'h7F, {MSG_PROGRAM, 4'hF}, 8'h80};
    send_chunk(1'b0);
  endtask

  // empty meta, running status restored after it, sysex with skipped payload, one-byte text meta
  task automatic test_meta_and_sysex();
    chunk = '{8'h00, mtep_pkg::ST_META, META_END_OF_TRACK, 8'h00,
              8'h00, 8'h55,
              8'h81, 8'h00, mtep_pkg::ST_SYSEX_ESC, 8'h01, 8'hFF,
              8'h00, mtep_pkg::ST_META, META_TXT, 8'h01, 8'hFF};
    send_chunk(1'b0);
  endtask

  // bad status, running status with none in effect, track start mid-event
  task automatic test_bad_status_and_restarts();
    chunk = '{8'h00, ST_SYS_LAST};
    send_chunk(1'b0);
    chunk = '{8'h05, 8'h10, mtep_pkg::ST_SYSEX, 8'h00, 8'h00, {MSG_NOTE_ON, 4'hF}, 8'h01};
    send_chunk(1'b1);
    chunk = '{8'h00, {MSG_NOTE_ON, 4'hF}, 8'h01, 8'h7F};
    send_chunk(1'b1);
  endtask

  task automatic test_random_tracks();
    run_tracks(1400);
  endtask

  // closing stretch with no gaps and no stalls
  task automatic test_unstalled_tracks();
    idle_on = 1'b0;
    run_tracks(1600);
  endtask

  initial begin
    clear_parse_state();
    last_status = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_channel_messages();
    test_meta_and_sysex();
    test_bad_status_and_restarts();
    test_random_tracks();
    test_unstalled_tracks();
    in_valid <= 1'b0;
    wait (pending_records.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mtep_pkg.sv
design/mtep_parser.sv
design/midi_track_event_parser_core.sv
dv/midi_track_event_parser_core_test.sv
